### rtl/gpr_pkg.sv
`timescale 1ns / 1ps

package gpr_pkg;

   localparam int NUM_PINS = 16;

   localparam int WORD_W    = 32;
   localparam int PINS_W    = 16;
   localparam int KEY_POS   = 16;

   localparam logic [PINS_W-1:0] PORT_PINS =
      PINS_W'((32'd1 << NUM_PINS) - 32'd1);

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      REG_MODE     = 4'd0,
      REG_TYPE     = 4'd1,
      REG_SPEED    = 4'd2,
      REG_PULL     = 4'd3,
      REG_INPUT    = 4'd4,
      REG_LATCH    = 4'd5,
      REG_SETRESET = 4'd6,
      REG_LOCK     = 4'd7,
      REG_AF_LOW   = 4'd8,
      REG_AF_HIGH  = 4'd9
   } reg_sel_type;

   typedef enum logic [1:0] {
      LOCK_IDLE    = 2'd0,
      LOCK_ARMED   = 2'd1,
      LOCK_CONFIRM = 2'd2
   } lock_phase_type;

   typedef struct packed {
      opcode_type        opcode;
      reg_sel_type       reg_select;
      logic [WORD_W-1:0] write_data;
      logic [PINS_W-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [PINS_W-1:0] output_latch;
      logic              write_ignored;
   } rsp_type;

   // one pin bit widened to a two-bit field
   function automatic logic [WORD_W-1:0] spread2(input logic [PINS_W-1:0] pins);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < PINS_W; i++) begin
         r[2*i +: 2] = {2{pins[i]}};
      end
      return r;
   endfunction

   // one pin bit of an eight-pin half widened to a four-bit field
   function automatic logic [WORD_W-1:0] spread4(input logic [7:0] pins);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[4*i +: 4] = {4{pins[i]}};
      end
      return r;
   endfunction

   localparam logic [WORD_W-1:0] V2_MASK    = spread2(PORT_PINS);
   localparam logic [WORD_W-1:0] AFL_MASK   = spread4(PORT_PINS[7:0]);
   localparam logic [WORD_W-1:0] AFH_MASK   = spread4(PORT_PINS[15:8]);
   localparam logic [WORD_W-1:0] MODE_RESET = V2_MASK;

endpackage

### rtl/gpr_core.sv
`timescale 1ns / 1ps

module gpr_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  gpr_pkg::req_type req,
   output gpr_pkg::rsp_type rsp
);
   import gpr_pkg::*;

   logic [WORD_W-1:0] mode_ff, mode_in;
   logic [PINS_W-1:0] type_ff, type_in;
   logic [WORD_W-1:0] speed_ff, speed_in;
   logic [WORD_W-1:0] pull_ff, pull_in;
   logic [WORD_W-1:0] afl_ff, afl_in;
   logic [WORD_W-1:0] afh_ff, afh_in;
   logic [PINS_W-1:0] latch_ff, latch_in;
   logic [PINS_W-1:0] frozen_ff, frozen_in;
   logic              key_ff, key_in;
   lock_phase_type    phase_ff, phase_in;
   logic [PINS_W-1:0] seq_mask_ff, seq_mask_in;

   logic              is_write;
   logic              lock_flag;
   logic              lock_key;
   logic [PINS_W-1:0] lock_mask;
   logic [WORD_W-1:0] f2;
   logic [PINS_W-1:0] f1;
   logic [WORD_W-1:0] fl4;
   logic [WORD_W-1:0] fh4;
   logic [WORD_W-1:0] wd;
   logic [PINS_W-1:0] set_bits;
   logic [PINS_W-1:0] clr_bits;

   assign is_write  = (req.opcode == OP_WRITE);
   assign wd        = req.write_data;
   assign lock_key  = wd[KEY_POS];
   assign lock_mask = wd[PINS_W-1:0] & PORT_PINS;
   assign f2        = spread2(frozen_ff) & V2_MASK;
   assign f1        = frozen_ff & PORT_PINS;
   assign fl4       = spread4(frozen_ff[7:0]) & AFL_MASK;
   assign fh4       = spread4(frozen_ff[15:8]) & AFH_MASK;
   assign set_bits  = wd[PINS_W-1:0] & PORT_PINS;
   assign clr_bits  = wd[2*PINS_W-1:PINS_W] & PORT_PINS;

   // lock sequence next state
   always_comb begin
      phase_in    = phase_ff;
      seq_mask_in = seq_mask_ff;
      frozen_in   = frozen_ff;
      key_in      = key_ff;
      lock_flag   = 1'b0;
      if (is_write && req.reg_select == REG_LOCK) begin
         if (key_ff) begin
            lock_flag = 1'b1;
         end else if (phase_ff == LOCK_ARMED && !lock_key && lock_mask == seq_mask_ff) begin
            phase_in = LOCK_CONFIRM;
         end else if (phase_ff == LOCK_CONFIRM && lock_key && lock_mask == seq_mask_ff) begin
            frozen_in = lock_mask;
            key_in    = 1'b1;
            phase_in  = LOCK_IDLE;
         end else if (lock_key) begin
            phase_in    = LOCK_ARMED;
            seq_mask_in = lock_mask;
         end else begin
            phase_in    = LOCK_IDLE;
            seq_mask_in = '0;
         end
      end
   end

   // register file update and read mux
   always_comb begin
      mode_in  = mode_ff;
      type_in  = type_ff;
      speed_in = speed_ff;
      pull_in  = pull_ff;
      afl_in   = afl_ff;
      afh_in   = afh_ff;
      latch_in = latch_ff;
      rsp      = '0;
      if (!is_write) begin
         case (req.reg_select)
            REG_MODE:    rsp.read_data = mode_ff;
            REG_TYPE:    rsp.read_data = WORD_W'(type_ff);
            REG_SPEED:   rsp.read_data = speed_ff;
            REG_PULL:    rsp.read_data = pull_ff;
            REG_INPUT:   rsp.read_data = WORD_W'(req.pin_levels & PORT_PINS);
            REG_LATCH:   rsp.read_data = WORD_W'(latch_ff);
            REG_LOCK:    rsp.read_data = {{(WORD_W-PINS_W-1){1'b0}}, key_ff, frozen_ff};
            REG_AF_LOW:  rsp.read_data = afl_ff;
            REG_AF_HIGH: rsp.read_data = afh_ff;
            default:     rsp.read_data = '0;
         endcase
      end else begin
         case (req.reg_select)
            REG_MODE: begin
               rsp.write_ignored = |((wd ^ mode_ff) & f2);
               mode_in = (mode_ff & f2) | (wd & V2_MASK & ~f2);
            end
            REG_TYPE: begin
               rsp.write_ignored = |((wd[PINS_W-1:0] ^ type_ff) & f1);
               type_in = (type_ff & f1) | (wd[PINS_W-1:0] & PORT_PINS & ~f1);
            end
            REG_SPEED: begin
               rsp.write_ignored = |((wd ^ speed_ff) & f2);
               speed_in = (speed_ff & f2) | (wd & V2_MASK & ~f2);
            end
            REG_PULL: begin
               rsp.write_ignored = |((wd ^ pull_ff) & f2);
               pull_in = (pull_ff & f2) | (wd & V2_MASK & ~f2);
            end
            REG_LATCH:    latch_in = set_bits;
            REG_SETRESET: latch_in = ((latch_ff & ~clr_bits) | set_bits) & PORT_PINS;
            REG_LOCK:     rsp.write_ignored = lock_flag;
            REG_AF_LOW: begin
               rsp.write_ignored = |((wd ^ afl_ff) & fl4);
               afl_in = (afl_ff & fl4) | (wd & AFL_MASK & ~fl4);
            end
            REG_AF_HIGH: begin
               rsp.write_ignored = |((wd ^ afh_ff) & fh4);
               afh_in = (afh_ff & fh4) | (wd & AFH_MASK & ~fh4);
            end
            default: rsp.write_ignored = 1'b1;
         endcase
      end
      rsp.output_latch = latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         type_ff     <= '0;
         speed_ff    <= '0;
         pull_ff     <= '0;
         afl_ff      <= '0;
         afh_ff      <= '0;
         latch_ff    <= '0;
         frozen_ff   <= '0;
         key_ff      <= 1'b0;
         phase_ff    <= LOCK_IDLE;
         seq_mask_ff <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         type_ff     <= type_in;
         speed_ff    <= speed_in;
         pull_ff     <= pull_in;
         afl_ff      <= afl_in;
         afh_ff      <= afh_in;
         latch_ff    <= latch_in;
         frozen_ff   <= frozen_in;
         key_ff      <= key_in;
         phase_ff    <= phase_in;
         seq_mask_ff <= seq_mask_in;
      end
   end

endmodule

### rtl/gpio_port_register_block.sv
`timescale 1ns / 1ps

// register block of one 16-pin gpio port
// request channel (req_valid/req_ready): one bus access per request, a read or
//   a write of the register picked by req_reg_select, with the pin levels
//   sampled alongside
// response channel (rsp_valid/rsp_ready): one response per request carrying
//   the read data, the output latch after the access and the ignored-write flag
// a request is taken into an input register, executed by the register file
//   logic when the output register can take the response, which it then holds
// throughput: one request per cycle while the receiver does not stall, set by
//   the register file update between the input and output registers
// when the receiver stalls the output register holds its response and the
//   input register holds one more request; req_ready drops only once both are
//   full
// reset: synchronous, active high; both stages empty, mode fields analog,
//   every other register zero, lock sequence idle and no pins frozen
module gpio_port_register_block (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [3:0]  req_reg_select,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [15:0] rsp_output_latch,
   output logic        rsp_write_ignored
);
   import gpr_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    req_fire;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   gpr_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff.opcode     <= opcode_type'(req_opcode);
         in_req_ff.reg_select <= reg_sel_type'(req_reg_select);
         in_req_ff.write_data <= req_write_data;
         in_req_ff.pin_levels <= req_pin_levels;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_rsp_ff.read_data;
   assign rsp_output_latch  = out_rsp_ff.output_latch;
   assign rsp_write_ignored = out_rsp_ff.write_ignored;

   // a read never raises the ignored-write flag
   assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.opcode == OP_READ |=> !rsp_write_ignored)
      else $error("read response flagged as ignored write");

   // a write always returns zero read data
   assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.opcode == OP_WRITE |=> rsp_read_data == '0)
      else $error("write response carries read data");

   // an executed request always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("executed request lost");

   // back-pressure only when both stages are full and the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled without cause");

endmodule
